[rtl/ohlc_pkg.sv]
// ohlc_pkg: shared types and constants of the candle aggregator
package ohlc_pkg;

	localparam int unsigned MAX_FILL_DEFAULT = 63;
	localparam logic [15:0] PERIOD_RESET = 16'd60;

	// one trade item
	typedef struct packed {
		logic [31:0] trade_time;
		logic [31:0] trade_price;
	} trade_t;

	// one candle item
	typedef struct packed {
		logic [31:0] open_price;
		logic [31:0] high_price;
		logic [31:0] low_price;
		logic [31:0] close_price;
		logic [31:0] start_time;
		logic        last_of_run;
	} candle_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic init;
		logic load_rem;
		logic first;
		logic look;
		logic step;
		logic roll;
		logic update;
	} ohlc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic started;
		logic early;
		logic ge;
		logic more;
	} ohlc_stat_t;

endpackage

[rtl/ohlc_dp.sv]
// ohlc_dp: candle state, period register, gap counter and output register
module ohlc_dp import ohlc_pkg::*; #(
	parameter int unsigned MAX_FILL = MAX_FILL_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  trade_t      in_item,
	input  ohlc_cmd_t   cmd,
	output ohlc_stat_t  stat,
	output candle_t     out_item
);

	localparam int unsigned CntW = $clog2(MAX_FILL + 1);

	logic [15:0]     period_q;
	logic            started_q;
	logic [31:0]     open_q, high_q, low_q, close_q, start_q;
	logic [31:0]     time_q, price_q;
	logic [31:0]     rem_q, stamp_q;
	logic [CntW-1:0] cnt_q;
	logic            more_q;
	candle_t         out_q;

	logic [31:0] per32;
	logic        ge;
	logic        more;

	// a zero period behaves as one second
	assign per32 = {16'b0, (period_q == 16'd0) ? 16'd1 : period_q};
	assign ge    = rem_q >= per32;
	assign more  = ge && (cnt_q < CntW'(MAX_FILL));

	assign stat.started = started_q;
	assign stat.early   = time_q < start_q;
	assign stat.ge      = ge;
	assign stat.more    = more_q;
	assign out_item     = out_q;

	// period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// captured trade
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			time_q  <= in_item.trade_time;
			price_q <= in_item.trade_price;
		end
	end

	// current candle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			open_q    <= '0;
			high_q    <= '0;
			low_q     <= '0;
			close_q   <= '0;
			start_q   <= '0;
		end else if (cmd.init) begin
			started_q <= 1'b1;
			open_q    <= price_q;
			high_q    <= price_q;
			low_q     <= price_q;
			close_q   <= price_q;
			start_q   <= time_q;
		end else if (cmd.roll) begin
			open_q  <= close_q;
			high_q  <= close_q;
			low_q   <= close_q;
			start_q <= time_q;
		end else if (cmd.update) begin
			close_q <= price_q;
			if (price_q > high_q) begin
				high_q <= price_q;
			end
			if (price_q < low_q) begin
				low_q <= price_q;
			end
		end
	end

	// elapsed time walked down one period per candle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			stamp_q <= '0;
			cnt_q   <= '0;
			more_q  <= 1'b0;
		end else begin
			if (cmd.load_rem) begin
				rem_q <= time_q - start_q;
			end else if (cmd.first) begin
				rem_q   <= rem_q - per32;
				stamp_q <= start_q;
				cnt_q   <= '0;
			end else if (cmd.step) begin
				rem_q   <= rem_q - per32;
				stamp_q <= stamp_q + per32;
				cnt_q   <= cnt_q + 1'b1;
			end
			if (cmd.look) begin
				more_q <= more;
			end
		end
	end

	// output register: finished candle first, then flat fill candles
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			if (cnt_q == '0) begin
				out_q.open_price  <= open_q;
				out_q.high_price  <= high_q;
				out_q.low_price   <= low_q;
				out_q.close_price <= close_q;
				out_q.start_time  <= start_q;
			end else begin
				out_q.open_price  <= close_q;
				out_q.high_price  <= close_q;
				out_q.low_price   <= close_q;
				out_q.close_price <= close_q;
				out_q.start_time  <= stamp_q;
			end
			out_q.last_of_run <= !more;
		end
	end

endmodule

[rtl/ohlc_ctrl.sv]
// ohlc_ctrl: sequencer for one trade item and its candles
module ohlc_ctrl import ohlc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  ohlc_stat_t stat,
	output ohlc_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SUB  = 7'b0000010,
		ST_CMP  = 7'b0000100,
		ST_LOOK = 7'b0001000,
		ST_WAIT = 7'b0010000,
		ST_ROLL = 7'b0100000,
		ST_UPD  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = state_q == ST_WAIT;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_SUB;
				end
			end
			ST_SUB: begin
				if (!stat.started) begin
					cmd.init = 1'b1;
					state_d  = ST_IDLE;
				end else if (stat.early) begin
					state_d = ST_UPD;
				end else begin
					cmd.load_rem = 1'b1;
					state_d      = ST_CMP;
				end
			end
			ST_CMP: begin
				if (stat.ge) begin
					cmd.first = 1'b1;
					state_d   = ST_LOOK;
				end else begin
					state_d = ST_UPD;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_WAIT;
			end
			ST_WAIT: begin
				if (!out_stall) begin
					if (stat.more) begin
						cmd.step = 1'b1;
						state_d  = ST_LOOK;
					end else begin
						state_d = ST_ROLL;
					end
				end
			end
			ST_ROLL: begin
				cmd.roll = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/ohlc_candle_aggregator_unit.sv]
// ohlc_candle_aggregator_unit: top level of the OHLC candle aggregator
// Takes one trade item at a time and returns the candles it closes: the
// finished candle, then at most MAX_FILL flat fill candles. The first trade
// after reset only starts a candle. The time a trade takes grows with the
// number of candles it emits, plus any output stall, set by the single
// compare-and-subtract unit that walks the elapsed time down one period
// per candle and the output register it waits on. Input stall stays high
// until the last candle of a trade has been taken and the state updated.
module ohlc_candle_aggregator_unit import ohlc_pkg::*; #(
	parameter int unsigned MAX_FILL = MAX_FILL_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  trade_t      in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output candle_t     out_item
);

	ohlc_cmd_t  cmd;
	ohlc_stat_t stat;

	// sequencer
	ohlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// candle state and arithmetic
	ohlc_dp #(
		.MAX_FILL (MAX_FILL)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_item  (out_item)
	);

`ifndef SYNTHESIS
	// no new trade is taken while a candle is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("trade item accepted while candle pending");

	// the last candle of a run ends the burst
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_item.last_of_run) |=> !out_valid)
		else $error("candle offered after last of run");

	// a candle that is not the last is followed by another
	a_run_goes_on: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_item.last_of_run) |-> ##2 out_valid)
		else $error("run of candles ended without last marker");
`endif

endmodule
